// ===== hw/rtl/llqs_pkg.sv =====
// shared types and constants of the least loaded queue select unit
package llqs_pkg;

  // sizing
  localparam int MAX_QUEUES    = 16;
  localparam int LOAD_BITS     = 16;
  localparam int IDX_BITS      = $clog2(MAX_QUEUES);
  localparam int CNT_BITS      = $clog2(MAX_QUEUES + 1);
  localparam int FIELD_BITS    = 16;
  localparam int RAND_BITS     = 32;
  localparam int NUM_BITS      = 5;
  localparam int MOD_STEP      = 4;
  localparam int MOD_CYCLES    = RAND_BITS / MOD_STEP;
  localparam int MOD_CNT_BITS  = $clog2(MOD_CYCLES);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  // largest load value, saturation point
  localparam logic [31:0] LOAD_MAX = 32'((33'd1 << LOAD_BITS) - 33'd1);

  // incoming queue status word
  typedef struct packed {
    logic [FIELD_BITS-1:0] used_local;
    logic [FIELD_BITS-1:0] used_remote;
    logic [FIELD_BITS-1:0] limit_local;
    logic [FIELD_BITS-1:0] limit_remote;
    logic                  disabled;
    logic [RAND_BITS-1:0]  random_word;
    logic                  last_queue;
  } rec_t;

  // outgoing selection word
  typedef struct packed {
    logic [NUM_BITS-1:0] queue_number;
    logic                none_eligible;
  } res_t;

  // classified record passed from front to back
  typedef struct packed {
    logic                 elig;
    logic [LOAD_BITS-1:0] load;
    logic                 last;
    logic [RAND_BITS-1:0] rnd;
  } cls_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic valid;
    cls_t word;
  } head_t;

  // stored load entry
  typedef struct packed {
    logic                 elig;
    logic [LOAD_BITS-1:0] load;
  } entry_t;

  // back part states
  typedef enum logic [1:0] {
    S_ACC,
    S_MOD,
    S_WALK,
    S_EMIT
  } back_state_t;

endpackage

// ===== hw/rtl/llqs_front.sv =====
// front part: eligibility and saturated load of each status word
module llqs_front (
  input  llqs_pkg::rec_t rec,
  output llqs_pkg::cls_t cls
);
  import llqs_pkg::*;

  logic [FIELD_BITS-1:0] mx;

  // larger of the two usages, saturated to the load width
  assign mx = (rec.used_local > rec.used_remote) ? rec.used_local : rec.used_remote;

  always_comb begin
    cls.elig = !rec.disabled && (rec.limit_local != '0) && (rec.limit_remote != '0);
    if (32'(mx) > LOAD_MAX) begin
      cls.load = LOAD_BITS'(LOAD_MAX);
    end else begin
      cls.load = LOAD_BITS'(mx);
    end
    cls.last = rec.last_queue;
    cls.rnd  = rec.random_word;
  end

endmodule

// ===== hw/rtl/llqs_queue.sv =====
// short queue of classified words between front and back
module llqs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  llqs_pkg::cls_t push_word,
  output logic           full,
  input  logic           pop_ready,
  output llqs_pkg::head_t head
);
  import llqs_pkg::*;

  cls_t                   mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;
  logic                     do_push;
  logic                     do_pop;

  assign full    = (count == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = (count != '0) && pop_ready;

  assign head.valid = (count != '0);
  assign head.word  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/llqs_back.sv =====
// back part: running minimum, tie remainder, walk over stored loads, result register
module llqs_back (
  input  logic            clk,
  input  logic            rst,
  input  llqs_pkg::head_t head,
  output logic            pop_ready,
  output logic            res_valid,
  input  logic            res_stall,
  output llqs_pkg::res_t  res
);
  import llqs_pkg::*;

  back_state_t state, state_next;

  entry_t                  store [MAX_QUEUES];
  logic                    store_we;
  entry_t                  store_wdata;

  logic [LOAD_BITS-1:0]    min_load, min_load_next;
  logic                    have_min, have_min_next;
  logic [CNT_BITS-1:0]     tie_count, tie_count_next;
  logic [CNT_BITS-1:0]     queue_index, queue_index_next;
  logic [RAND_BITS-1:0]    rnd, rnd_next;
  logic [CNT_BITS-1:0]     rem, rem_next;
  logic [MOD_CNT_BITS-1:0] mod_cnt, mod_cnt_next;
  logic [CNT_BITS-1:0]     walk_i, walk_i_next;
  logic [CNT_BITS-1:0]     seen, seen_next;
  logic [NUM_BITS-1:0]     pick, pick_next;
  logic                    none, none_next;
  logic                    res_valid_next;
  res_t                    res_next;

  logic [CNT_BITS-1:0]     mod_rem;
  entry_t                  walk_entry;
  logic                    walk_hit;

  // remainder of random_word modulo the tie count, MOD_STEP bits per cycle, restoring style
  always_comb begin
    logic [CNT_BITS:0]   t;
    logic [CNT_BITS-1:0] r;
    r = rem;
    for (int k = 0; k < MOD_STEP; k++) begin
      t = {r, rnd[RAND_BITS-1-k]};
      if (t >= {1'b0, tie_count}) begin
        r = CNT_BITS'(t - {1'b0, tie_count});
      end else begin
        r = t[CNT_BITS-1:0];
      end
    end
    mod_rem = r;
  end

  assign walk_hit   = walk_entry.elig && (walk_entry.load == min_load);

  // next state and datapath updates
  always_comb begin
    state_next       = state;
    min_load_next    = min_load;
    have_min_next    = have_min;
    tie_count_next   = tie_count;
    queue_index_next = queue_index;
    rnd_next         = rnd;
    rem_next         = rem;
    mod_cnt_next     = mod_cnt;
    walk_i_next      = walk_i;
    seen_next        = seen;
    pick_next        = pick;
    none_next        = none;
    res_valid_next   = res_valid && res_stall;
    res_next         = res;
    store_we         = 1'b0;
    store_wdata      = '{elig: head.word.elig, load: head.word.load};
    pop_ready        = 1'b0;

    case (state)
      S_ACC: begin
        pop_ready = 1'b1;
        if (head.valid) begin
          // fold one word into the running minimum
          if (queue_index < CNT_BITS'(MAX_QUEUES)) begin
            store_we         = 1'b1;
            queue_index_next = queue_index + 1'b1;
            if (head.word.elig) begin
              if (!have_min || head.word.load < min_load) begin
                min_load_next  = head.word.load;
                have_min_next  = 1'b1;
                tie_count_next = CNT_BITS'(1);
              end else if (head.word.load == min_load) begin
                tie_count_next = tie_count + 1'b1;
              end
            end
          end
          if (head.word.last) begin
            rnd_next     = head.word.rnd;
            rem_next     = '0;
            mod_cnt_next = '0;
            if (have_min_next) begin
              state_next = S_MOD;
            end else begin
              pick_next  = NUM_BITS'(1);
              none_next  = 1'b1;
              state_next = S_EMIT;
            end
          end
        end
      end
      S_MOD: begin
        rem_next     = mod_rem;
        rnd_next     = {rnd[RAND_BITS-MOD_STEP-1:0], MOD_STEP'(0)};
        mod_cnt_next = mod_cnt + 1'b1;
        if (mod_cnt == MOD_CNT_BITS'(MOD_CYCLES - 1)) begin
          walk_i_next = '0;
          seen_next   = '0;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        // pick the tied queue whose rank equals the remainder
        walk_i_next = walk_i + 1'b1;
        if (walk_hit) begin
          if (seen == rem) begin
            pick_next  = NUM_BITS'(walk_i + 1'b1);
            none_next  = 1'b0;
            state_next = S_EMIT;
          end else begin
            seen_next = seen + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_valid_next   = 1'b1;
          res_next         = '{queue_number: pick, none_eligible: none};
          min_load_next    = '0;
          have_min_next    = 1'b0;
          tie_count_next   = '0;
          queue_index_next = '0;
          state_next       = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_load    <= '0;
      have_min    <= 1'b0;
      tie_count   <= '0;
      queue_index <= '0;
      res_valid   <= 1'b0;
    end else begin
      min_load    <= min_load_next;
      have_min    <= have_min_next;
      tie_count   <= tie_count_next;
      queue_index <= queue_index_next;
      res_valid   <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rnd     <= rnd_next;
    rem     <= rem_next;
    mod_cnt <= mod_cnt_next;
    walk_i  <= walk_i_next;
    seen    <= seen_next;
    pick    <= pick_next;
    none    <= none_next;
    res     <= res_next;
  end

  // load store, read one entry ahead of the walk
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[queue_index[IDX_BITS-1:0]] <= store_wdata;
    end
    walk_entry <= store[walk_i_next[IDX_BITS-1:0]];
  end

  // tie count never exceeds the number of stored words
  assert property (@(posedge clk) disable iff (rst) tie_count <= queue_index)
    else $error("tie count exceeds stored queue count");

  // no ties without a minimum
  assert property (@(posedge clk) disable iff (rst) !have_min |-> (tie_count == '0))
    else $error("ties counted with no eligible queue");

  // remainder and walk only run when an eligible queue exists
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD || state == S_WALK) |-> (have_min && tie_count != '0))
    else $error("tie break running without eligible queue");

  // walk finds its pick before running past the stored words
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_i < queue_index && seen <= rem))
    else $error("walk ran past the stored words");

endmodule

// ===== hw/rtl/least_loaded_queue_select_unit.sv =====
// Least loaded queue select unit. One status word per queue arrives on the rec channel in queue
// order, the final one marked by last_queue; the unit answers each set with one word on the res
// channel naming the least loaded eligible queue, ties broken by random_word modulo the tie
// count. The front classifies words and a four-entry queue lets the sender run ahead. Closing a set
// computes the tie remainder (four bits of random_word per cycle), walks the stored queues up to
// the chosen one and loads the result register; with no eligible queue it goes straight to the
// result register.
module least_loaded_queue_select_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  output logic           rec_stall,
  input  llqs_pkg::rec_t rec,
  output logic           res_valid,
  input  logic           res_stall,
  output llqs_pkg::res_t res
);
  import llqs_pkg::*;

  cls_t  cls;
  head_t head;
  logic  full;
  logic  pop_ready;

  assign rec_stall = full;

  llqs_front u_front (
    .rec (rec),
    .cls (cls)
  );

  llqs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_valid),
    .push_word (cls),
    .full      (full),
    .pop_ready (pop_ready),
    .head      (head)
  );

  llqs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop_ready (pop_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== bench/least_loaded_queue_select_checker.sv =====
// checker that predicts and compares the selection words of the least loaded queue select unit
module least_loaded_queue_select_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  input  logic           rec_stall,
  input  llqs_pkg::rec_t rec,
  input  logic           res_valid,
  input  logic           res_stall,
  input  llqs_pkg::res_t res,
  output int             mismatches,
  output int             picks_pending,
  output int             sets_seen,
  output int             tie_sets,
  output int             empty_sets,
  output int             long_sets
);
  import llqs_pkg::*;

  // per-set copy of the unit's state
  entry_t               load_tab [MAX_QUEUES];
  logic [LOAD_BITS-1:0] low_load;
  logic                 seen_elig;
  int unsigned          tie_n;
  int unsigned          set_len;
  int unsigned          words_in_set;

  // picks still owed by the unit, oldest first
  res_t pick_q [$];

  // start a fresh set
  task automatic clear_set();
    for (int i = 0; i < MAX_QUEUES; i++) begin
      load_tab[i] = '0;
    end
    low_load     = '0;
    seen_elig    = 1'b0;
    tie_n        = 0;
    set_len      = 0;
    words_in_set = 0;
  endtask

  // count a mismatch, report only the first ten
  task automatic note_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    end
  endtask

  initial begin
    mismatches    = 0;
    picks_pending = 0;
    sets_seen     = 0;
    tie_sets      = 0;
    empty_sets    = 0;
    long_sets     = 0;
    clear_set();
  end

  always @(posedge clk) begin : watch_edge
    logic [31:0] load32;
    logic        ok;
    logic        found;
    res_t        pick;
    res_t        owed;
    int unsigned want;
    int unsigned seen;

    if (rst) begin
      clear_set();
      pick_q.delete();
    end else begin
      // status word taken: classify and fold into the set
      if (rec_valid && !rec_stall) begin
        words_in_set++;
        if (set_len < MAX_QUEUES) begin
          ok = !rec.disabled && rec.limit_local != 0 && rec.limit_remote != 0;
          load32 = (rec.used_local > rec.used_remote) ? 32'(rec.used_local)
                                                      : 32'(rec.used_remote);
          if (load32 > LOAD_MAX) begin
            load32 = LOAD_MAX;
          end
          load_tab[set_len].elig = ok;
          load_tab[set_len].load = ok ? load32[LOAD_BITS-1:0] : '0;
          if (ok) begin
            if (!seen_elig || load32 < 32'(low_load)) begin
              low_load  = load32[LOAD_BITS-1:0];
              seen_elig = 1'b1;
              tie_n     = 1;
            end else if (load32 == 32'(low_load)) begin
              tie_n++;
            end
          end
          set_len++;
        end

        // marked word closes the set: walk the tied queues
        if (rec.last_queue) begin
          pick.queue_number = NUM_BITS'(1);
          pick.none_eligible = 1'b1;
          if (seen_elig && tie_n != 0) begin
            want  = rec.random_word % tie_n;
            seen  = 0;
            found = 1'b0;
            pick.none_eligible = 1'b0;
            for (int i = 0; i < MAX_QUEUES; i++) begin
              if (!found && i < set_len && load_tab[i].elig && load_tab[i].load == low_load)
              begin
                if (seen == want) begin
                  pick.queue_number = NUM_BITS'(i + 1);
                  found = 1'b1;
                end
                seen++;
              end
            end
          end
          pick_q.push_back(pick);
          sets_seen++;
          if (pick.none_eligible) empty_sets++;
          if (tie_n > 1) tie_sets++;
          if (words_in_set > MAX_QUEUES) long_sets++;
          clear_set();
        end
      end

      // selection word taken: compare with the oldest pick
      if (res_valid && !res_stall) begin
        if (pick_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("selection word with no pick pending: queue %0d, none %0b",
                     res.queue_number, res.none_eligible);
          end
        end else begin
          owed = pick_q.pop_front();
          if (res.queue_number !== owed.queue_number) begin
            note_mismatch("queue_number", owed.queue_number, res.queue_number);
          end
          if (res.none_eligible !== owed.none_eligible) begin
            note_mismatch("none_eligible", owed.none_eligible, res.none_eligible);
          end
        end
      end
    end
    picks_pending = pick_q.size();
  end

endmodule

// ===== bench/least_loaded_queue_select_unit_tb.sv =====
// testbench top: stimulus, idling and verdict for the least loaded queue select unit
module least_loaded_queue_select_unit_tb;
  import llqs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int WORD_TARGET  = 1700;
  localparam int IDLE_PCT     = 23;

  logic clk;
  logic rst;
  logic rec_valid;
  logic rec_stall;
  rec_t rec;
  logic res_valid;
  logic res_stall;
  res_t res;

  int mismatches;
  int picks_pending;
  int sets_seen;
  int tie_sets;
  int empty_sets;
  int long_sets;

  int words_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int cycle_count;

  least_loaded_queue_select_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  least_loaded_queue_select_checker watch (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec_stall     (rec_stall),
    .rec           (rec),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res),
    .mismatches    (mismatches),
    .picks_pending (picks_pending),
    .sets_seen     (sets_seen),
    .tie_sets      (tie_sets),
    .empty_sets    (empty_sets),
    .long_sets     (long_sets)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // status word from its fields
  function automatic rec_t status(input logic [15:0] ul, input logic [15:0] ur,
                                  input logic [15:0] ll, input logic [15:0] lr,
                                  input logic dis, input logic [31:0] rnd, input logic last);
    rec_t w;
    w.used_local   = ul;
    w.used_remote  = ur;
    w.limit_local  = ll;
    w.limit_remote = lr;
    w.disabled     = dis;
    w.random_word  = rnd;
    w.last_queue   = last;
    return w;
  endfunction

  // offer one word, called at a falling edge, returns at a falling edge
  task automatic put_word(input rec_t w);
    rec       <= w;
    rec_valid <= 1'b1;
    @(posedge clk);
    while (rec_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rec_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : recv_side
    int held;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        held = hold_len;
        hold_len = 0;
        res_stall <= 1'b1;
        repeat (held) @(negedge clk);
      end
      res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles", cycle_count);
    $display("least_loaded_queue_select_unit_tb failed");
    $finish;
  end

  // stimulus and verdict
  initial begin : stim
    rec_t        w;
    int unsigned len;
    int unsigned span;
    int unsigned skip_pct;
    int unsigned r;
    bit          small_rnd;
    bit          held_once;
    bit          drained_once;

    rst           = 1'b1;
    rec_valid     = 1'b0;
    rec           = '0;
    res_stall     = 1'b0;
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    hold_len      = 0;
    words_sent    = 0;
    held_once     = 1'b0;
    drained_once  = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single queue, every numeric field at its top value
    put_word(status(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1));
    // single disabled queue: nothing eligible
    put_word(status(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, 1'b1));
    // each way of being ineligible: zero local limit, zero remote limit, disabled
    put_word(status(16'd5, 16'd3, 16'd0, 16'd7, 1'b0, 32'h0, 1'b0));
    put_word(status(16'd2, 16'd9, 16'd4, 16'd0, 1'b0, 32'h0, 1'b0));
    put_word(status(16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 32'h0, 1'b1));
    // minimum found late resets the tie count, disabled zero load ignored
    put_word(status(16'd9, 16'd2, 16'd3, 16'd3, 1'b0, 32'h0, 1'b0));
    put_word(status(16'd1, 16'd4, 16'd3, 16'd3, 1'b0, 32'h0, 1'b0));
    put_word(status(16'd4, 16'd4, 16'd3, 16'd3, 1'b0, 32'h0, 1'b0));
    put_word(status(16'd0, 16'd0, 16'd3, 16'd3, 1'b1, 32'h0, 1'b0));
    put_word(status(16'd4, 16'd0, 16'd3, 16'd3, 1'b0, 32'd5, 1'b1));
    // too many queues: the seventeenth word must not count
    for (int i = 0; i < MAX_QUEUES; i++) begin
      put_word(status(16'd5, 16'($urandom_range(0, 5)), 16'hFFFF, 16'd1, 1'b0, $urandom, 1'b0));
    end
    put_word(status(16'd0, 16'd0, 16'd1, 16'd1, 1'b0, 32'hFFFF_FFFF, 1'b1));

    // random sets
    while (words_sent < WORD_TARGET) begin
      // a stretch with no idling on either side
      if (words_sent >= 950 && words_sent < 1250) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
      end

      // long result hold-off while the sender keeps going
      if (!held_once && words_sent >= 400) begin
        held_once = 1'b1;
        hold_len  = 300;
      end

      // sender waits until every pick has come back
      if (!drained_once && words_sent >= 700) begin
        drained_once = 1'b1;
        rec_valid <= 1'b0;
        do @(negedge clk); while (picks_pending != 0);
      end

      r = $urandom_range(0, 99);
      if (r < 6) len = $urandom_range(MAX_QUEUES + 1, MAX_QUEUES + 4);
      else if (r < 30) len = $urandom_range(1, 4);
      else len = $urandom_range(5, MAX_QUEUES);

      r = $urandom_range(0, 2);
      span = (r == 0) ? 0 : (r == 1) ? 3 : 255;
      skip_pct = ($urandom_range(0, 99) < 8) ? 100 : $urandom_range(0, 40);
      small_rnd = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < len; i++) begin
        w.used_local   = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
        w.used_remote  = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
        w.limit_local  = 16'($urandom_range(1, 16'hFFFF));
        w.limit_remote = 16'($urandom_range(1, 16'hFFFF));
        w.disabled     = 1'b0;
        w.random_word  = $urandom;
        w.last_queue   = 1'b0;
        if ($urandom_range(0, 99) < skip_pct) begin
          case ($urandom_range(0, 3))
            0: w.disabled = 1'b1;
            1: w.limit_local = '0;
            2: w.limit_remote = '0;
            default: begin
              w.disabled     = 1'b1;
              w.limit_local  = '0;
              w.limit_remote = '0;
            end
          endcase
        end
        if (i == len - 1) begin
          w.last_queue = 1'b1;
          if (small_rnd) w.random_word = $urandom_range(0, 40);
        end
        put_word(w);
      end
    end

    rec_valid <= 1'b0;
    while (picks_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d status words in %0d sets: %0d with tied queues, %0d with none eligible,",
             words_sent, sets_seen, tie_sets, empty_sets);
    $display("%0d longer than the queue limit, under a long result hold-off and a full drain",
             long_sets);
    if (mismatches == 0) begin
      $display("least_loaded_queue_select_unit_tb passed");
    end else begin
      $display("least_loaded_queue_select_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/llqs_pkg.sv
hw/rtl/llqs_front.sv
hw/rtl/llqs_queue.sv
hw/rtl/llqs_back.sv
hw/rtl/least_loaded_queue_select_unit.sv
bench/least_loaded_queue_select_checker.sv
bench/least_loaded_queue_select_unit_tb.sv
